/* hdl/fxalu_pkg.sv */
// shared types and operation codes for the fixed-point alu
`default_nettype none

package fxalu_pkg;

  // operation codes
  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_INC      = 4'd4;
  localparam logic [3:0] OP_DEC      = 4'd5;
  localparam logic [3:0] OP_MIN      = 4'd6;
  localparam logic [3:0] OP_MAX      = 4'd7;
  localparam logic [3:0] OP_CMP      = 4'd8;
  localparam logic [3:0] OP_TO_INT   = 4'd9;
  localparam logic [3:0] OP_FROM_INT = 4'd10;

  // saturation bounds
  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               overflowed;
    logic               divided_by_zero;
  } out_t;

  // how the back end finishes a request
  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_t;

  // classified request passed from front to back
  typedef struct packed {
    cls_t               cls;
    out_t               res;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               neg;
  } item_t;

endpackage

`default_nettype wire

/* hdl/fxalu_front.sv */
// front end: classifies requests and completes every operation but multiply and non-zero divide
`default_nettype none

module fxalu_front
  import fxalu_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  in_t   req,
  output item_t itm
);

  localparam logic signed [63:0] W_MAX = 64'sd2147483647;
  localparam logic signed [63:0] W_MIN = -64'sd2147483648;

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic signed [32:0] sum;
  logic signed [32:0] dif;
  logic signed [32:0] inc;
  logic signed [32:0] dec;
  logic signed [63:0] wide;

  assign a    = req.operand_a;
  assign b    = req.operand_b;
  assign sum  = 33'(a) + 33'(b);
  assign dif  = 33'(a) - 33'(b);
  assign inc  = 33'(a) + 33'sd1;
  assign dec  = 33'(a) - 33'sd1;
  assign wide = 64'(a) <<< FRACTION_BITS;

  // decode and the results completed in the front end
  always_comb begin
    itm     = '0;
    itm.cls = CLS_DONE;
    itm.a   = a;
    itm.b   = b;
    itm.neg = a[31] ^ b[31];
    unique case (req.operation)
      OP_ADD: begin
        itm.res.overflowed   = sum[32] ^ sum[31];
        itm.res.result_value = itm.res.overflowed ? (sum[32] ? MIN32 : MAX32) : sum[31:0];
      end
      OP_SUB: begin
        itm.res.overflowed   = dif[32] ^ dif[31];
        itm.res.result_value = itm.res.overflowed ? (dif[32] ? MIN32 : MAX32) : dif[31:0];
      end
      OP_INC: begin
        itm.res.overflowed   = inc[32] ^ inc[31];
        itm.res.result_value = itm.res.overflowed ? MAX32 : inc[31:0];
      end
      OP_DEC: begin
        itm.res.overflowed   = dec[32] ^ dec[31];
        itm.res.result_value = itm.res.overflowed ? MIN32 : dec[31:0];
      end
      OP_MUL: itm.cls = CLS_MUL;
      OP_DIV: begin
        if (b == 32'sd0) begin
          itm.res.divided_by_zero = 1'b1;
        end else begin
          itm.cls = CLS_DIV;
        end
      end
      OP_MIN: itm.res.result_value = (a < b) ? a : b;
      OP_MAX: itm.res.result_value = (a > b) ? a : b;
      OP_CMP: begin
        itm.res.a_less    = a < b;
        itm.res.a_equal   = a == b;
        itm.res.a_greater = a > b;
      end
      OP_TO_INT: itm.res.result_value = a >>> FRACTION_BITS;
      OP_FROM_INT: begin
        if (wide > W_MAX) begin
          itm.res.overflowed   = 1'b1;
          itm.res.result_value = MAX32;
        end else if (wide < W_MIN) begin
          itm.res.overflowed   = 1'b1;
          itm.res.result_value = MIN32;
        end else begin
          itm.res.result_value = wide[31:0];
        end
      end
      default: itm.res = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/fxalu_queue.sv */
// two-entry queue between front and back end
`default_nettype none

module fxalu_queue
  import fxalu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_itm,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_itm
);

  item_t       mem_r [2];
  logic        wr_r;
  logic        wr_nxt;
  logic        rd_r;
  logic        rd_nxt;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        do_push;
  logic        do_pop;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_itm   = mem_r[rd_r];

  // pointer and fill count
  always_comb begin
    wr_nxt  = do_push ? !wr_r : wr_r;
    rd_nxt  = do_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_itm;
    end
  end

endmodule

`default_nettype wire

/* hdl/fxalu_back.sv */
// back end: pipelined multiply rounding and restoring divider, one request a cycle
`default_nettype none

module fxalu_back
  import fxalu_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  item_t in_itm,
  output logic out_vld,
  output out_t out_res
);

  localparam int NW = 32 + FRACTION_BITS;
  localparam logic [NW:0] Q_POS = (NW+1)'(33'h07fffffff);
  localparam logic [NW:0] Q_NEG = (NW+1)'(33'h080000000);
  localparam logic [63:0] HALF  = 64'd1 << (FRACTION_BITS - 1);

  logic        vld_r [NW+1];
  item_t       itm_r [NW+1];
  logic [31:0] rem_r [NW+1];
  logic [NW-1:0] nq_r [NW+1];
  logic signed [63:0] prod_r;
  logic [31:0] na;
  logic [31:0] nd;

  logic        ovld_r;
  out_t        ores_r;

  assign na = in_itm.a[31] ? (~in_itm.a + 32'd1) : in_itm.a;

  // entry stage: product and divider start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    itm_r[0]  <= in_itm;
    rem_r[0]  <= '0;
    nq_r[0]   <= {na, {FRACTION_BITS{1'b0}}};
    prod_r    <= in_itm.a * in_itm.b;
  end

  // divider stages, one quotient bit each
  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [32:0]   t;
    logic [31:0]   d;
    logic          ge;
    item_t         itm_nxt;
    logic [31:0]   rem_nxt;
    logic [NW-1:0] nq_nxt;
    logic [63:0]   mag;
    logic [63:0]   m;

    always_comb begin
      d       = itm_r[k-1].b[31] ? (~itm_r[k-1].b + 32'd1) : itm_r[k-1].b;
      t       = {rem_r[k-1], nq_r[k-1][NW-1]};
      ge      = t >= {1'b0, d};
      rem_nxt = ge ? 32'(t - {1'b0, d}) : t[31:0];
      nq_nxt  = {nq_r[k-1][NW-2:0], ge};
      itm_nxt = itm_r[k-1];
      mag     = '0;
      m       = '0;
      // multiply rounding in the first stage
      if (k == 1 && itm_r[k-1].cls == CLS_MUL) begin
        mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
        m   = (mag + HALF) >> FRACTION_BITS;
        if (!prod_r[63] && m > 64'h7fffffff) begin
          itm_nxt.res.overflowed   = 1'b1;
          itm_nxt.res.result_value = MAX32;
        end else if (prod_r[63] && m > 64'h80000000) begin
          itm_nxt.res.overflowed   = 1'b1;
          itm_nxt.res.result_value = MIN32;
        end else begin
          itm_nxt.res.result_value = prod_r[63] ? -m[31:0] : m[31:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      itm_r[k] <= itm_nxt;
      rem_r[k] <= rem_nxt;
      nq_r[k]  <= nq_nxt;
    end
  end

  // quotient rounding, saturation and result register
  logic [31:0] dl;
  logic [NW:0] q1;
  out_t        res_nxt;

  assign nd = dl;

  always_comb begin
    dl      = itm_r[NW].b[31] ? (~itm_r[NW].b + 32'd1) : itm_r[NW].b;
    q1      = {1'b0, nq_r[NW]} + (NW+1)'({rem_r[NW], 1'b0} >= {1'b0, nd});
    res_nxt = itm_r[NW].res;
    if (itm_r[NW].cls == CLS_DIV) begin
      if (!itm_r[NW].neg && q1 > Q_POS) begin
        res_nxt.overflowed   = 1'b1;
        res_nxt.result_value = MAX32;
      end else if (itm_r[NW].neg && q1 > Q_NEG) begin
        res_nxt.overflowed   = 1'b1;
        res_nxt.result_value = MIN32;
      end else begin
        res_nxt.result_value = itm_r[NW].neg ? -q1[31:0] : q1[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    ores_r <= res_nxt;
  end

  assign out_vld = ovld_r;
  assign out_res = ores_r;

endmodule

`default_nettype wire

/* hdl/fixed_point_alu.sv */
// top level of the fixed-point alu
//
//  channel  ports                    direction  transfer
//  request  start, busy, in_req      in         start && !busy
//  result   out_strobe, out_res      out        out_strobe, one cycle
//
// one request per cycle; every request passes the queue, the entry stage,
// the 32 + FRACTION_BITS stages of the restoring divider, which resolves one
// quotient bit per stage, and the result register before its result strobes,
// with every operation following the same path so order is kept.
// reset is synchronous; the queue and all stage valids clear.
// the back end never stalls, so busy stays low in operation.
`default_nettype none

module fixed_point_alu
  import fxalu_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_req,
  output logic out_strobe,
  output out_t out_res
);

  item_t f_itm;
  item_t q_itm;
  logic  q_full;
  logic  q_avail;

  // classify
  fxalu_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .req (in_req),
    .itm (f_itm)
  );

  // decoupling queue
  fxalu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_itm  (f_itm),
    .full      (q_full),
    .pop       (q_avail),
    .not_empty (q_avail),
    .pop_itm   (q_itm)
  );

  assign busy = q_full;

  // execute
  fxalu_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (q_avail),
    .in_itm  (q_itm),
    .out_vld (out_strobe),
    .out_res (out_res)
  );

  // checks
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $onehot0({out_res.a_less, out_res.a_equal, out_res.a_greater}))
    else $error("compare flags not exclusive");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.divided_by_zero) |->
      (out_res.result_value == 32'sd0 && !out_res.overflowed))
    else $error("divide by zero result not clean");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe after reset");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled");

endmodule

`default_nettype wire

/* bench/tb.sv */
// self-checking bench for the fixed-point alu: random and corner requests
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import fxalu_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = FRAC + 34;
  localparam int WATCHDOG = 2000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_req;
  logic out_strobe;
  out_t out_res;

  in_t  pending_reqs[$];
  out_t expected_res[$];
  int   sender_idle_pct;
  bit   hold_sender;
  bit   failed;
  int   quiet_cycles;
  bit   feeding_done;

  fixed_point_alu #(.FRACTION_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_strobe(out_strobe), .out_res(out_res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // clamp a wide value to 32 bits, flagging saturation
  function automatic logic signed [31:0] saturate(input logic signed [71:0] x,
                                                  inout logic ovf);
    if (x > 72'sd2147483647) begin
      ovf = 1'b1;
      return MAX32;
    end
    if (x < -72'sd2147483648) begin
      ovf = 1'b1;
      return MIN32;
    end
    return x[31:0];
  endfunction

  // expected alu result for one request
  function automatic out_t alu_result(input in_t rq);
    out_t r;
    logic signed [71:0] a, b, p, q;
    logic [71:0] mag, num, den;
    logic neg, ovf;
    r = '0;
    ovf = 1'b0;
    a = rq.operand_a;
    b = rq.operand_b;
    case (rq.operation)
      OP_ADD: r.result_value = saturate(a + b, ovf);
      OP_SUB: r.result_value = saturate(a - b, ovf);
      OP_MUL: begin
        p = a * b;
        neg = p < 0;
        mag = neg ? -p : p;
        mag = (mag + (72'd1 << (FRAC - 1))) >> FRAC;
        q = mag;
        r.result_value = saturate(neg ? -q : q, ovf);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.divided_by_zero = 1'b1;
        end else begin
          neg = (a < 0) != (b < 0);
          num = (a < 0 ? -a : a) << FRAC;
          den = b < 0 ? -b : b;
          q = (2 * num + den) / (2 * den);
          r.result_value = saturate(neg ? -q : q, ovf);
        end
      end
      OP_INC: r.result_value = saturate(a + 1, ovf);
      OP_DEC: r.result_value = saturate(a - 1, ovf);
      OP_MIN: r.result_value = (a < b) ? a[31:0] : b[31:0];
      OP_MAX: r.result_value = (a > b) ? a[31:0] : b[31:0];
      OP_CMP: begin
        r.a_less = a < b;
        r.a_equal = a == b;
        r.a_greater = a > b;
      end
      OP_TO_INT: r.result_value = rq.operand_a >>> FRAC;
      OP_FROM_INT: r.result_value = saturate(a * (72'sd1 << FRAC), ovf);
      default: ;
    endcase
    r.overflowed = ovf;
    return r;
  endfunction

  // random operand biased towards interesting values
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 600) - 300;
      3: return ($urandom_range(0, 1) ? 32'hffffffff : 32'h1) << $urandom_range(0, 31);
      4: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t make_req(input logic [3:0] op, input logic [31:0] a,
                                   input logic [31:0] b);
    in_t rq;
    rq.operation = op;
    rq.operand_a = a;
    rq.operand_b = b;
    return rq;
  endfunction

  // stimulus, in three idling phases
  initial begin
    logic [3:0] op;
    rst_n = 1'b0;
    sender_idle_pct = 14;
    hold_sender = 1'b0;
    feeding_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed corners
    pending_reqs.push_back(make_req(OP_ADD, 32'h7fffffff, 32'h1));
    pending_reqs.push_back(make_req(OP_SUB, 32'h80000000, 32'h1));
    pending_reqs.push_back(make_req(OP_MUL, 32'h7fffffff, 32'h7fffffff));
    pending_reqs.push_back(make_req(OP_MUL, 32'h80000000, 32'h80000000));
    pending_reqs.push_back(make_req(OP_MUL, 32'h80, 32'h1));
    pending_reqs.push_back(make_req(OP_MUL, 32'hffffff80, 32'h1));
    pending_reqs.push_back(make_req(OP_DIV, 32'h100, 32'h0));
    pending_reqs.push_back(make_req(OP_DIV, 32'h80000000, 32'h1));
    pending_reqs.push_back(make_req(OP_DIV, 32'h1, 32'h200));
    pending_reqs.push_back(make_req(OP_DIV, 32'hffffffff, 32'h200));
    pending_reqs.push_back(make_req(OP_DIV, 32'h80000000, 32'h80000000));
    pending_reqs.push_back(make_req(OP_INC, 32'h7fffffff, 32'h0));
    pending_reqs.push_back(make_req(OP_DEC, 32'h80000000, 32'h0));
    pending_reqs.push_back(make_req(OP_MIN, 32'h5, 32'h5));
    pending_reqs.push_back(make_req(OP_MAX, 32'h80000000, 32'h7fffffff));
    pending_reqs.push_back(make_req(OP_CMP, 32'h80000000, 32'h7fffffff));
    pending_reqs.push_back(make_req(OP_CMP, 32'h3, 32'h3));
    pending_reqs.push_back(make_req(OP_TO_INT, 32'hffffffff, 32'h0));
    pending_reqs.push_back(make_req(OP_TO_INT, 32'h80000000, 32'h0));
    pending_reqs.push_back(make_req(OP_FROM_INT, 32'h00800000, 32'h0));
    pending_reqs.push_back(make_req(OP_FROM_INT, 32'hff800000, 32'h0));
    pending_reqs.push_back(make_req(OP_FROM_INT, 32'hff7fffff, 32'h0));
    pending_reqs.push_back(make_req(4'd11, 32'hffffffff, 32'hffffffff));
    pending_reqs.push_back(make_req(4'd15, 32'h1, 32'h1));
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 51 : 0;
      for (int i = 0; i < 400; i++) begin
        op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
        pending_reqs.push_back(make_req(op, rand_operand(), rand_operand()));
      end
      // let the pipeline drain completely once per phase
      wait (pending_reqs.size() == 0);
      hold_sender = 1'b1;
      wait (expected_res.size() == 0);
      @(posedge clk);
      hold_sender = 1'b0;
    end
    feeding_done = 1'b1;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
    end else begin
      // the accepted request leaves the head of the queue
      if (start && !busy) begin
        expected_res.push_back(alu_result(in_req));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_req <= pending_reqs[0];
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_res);
        failed = 1'b1;
      end else begin
        exp_r = expected_res.pop_front();
        if (exp_r !== out_res) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_res);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    failed = 1'b0;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (feeding_done && pending_reqs.size() == 0 && expected_res.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        if (expected_res.size() != 0) failed = 1'b1;
        if (!failed) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
